// File: design/sim_pkg.sv
// Shared types, constants and key/match functions of the shader interface matcher.
package sim_pkg;

  // Operation codes carried by a request word
  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_BEGIN  = 2'd1,
    FUNC_CHECK  = 2'd2,
    FUNC_CLEAR  = 2'd3
  } sim_func_e;

  // One interface variable as held in the table (28 bits)
  typedef struct packed {
    logic        is_builtin;
    logic [15:0] code;
    logic [4:0]  location;
    logic [1:0]  comp_index;
    logic [2:0]  comp_count;
    logic        patch;
  } sim_entry_t;

  // Stage configuration seen by the sequencer
  typedef struct packed {
    logic [2:0] stage;
    logic [2:0] prev_stage;
  } sim_cfg_t;

  localparam int unsigned KEY_W = 24;

  // Register map, indexed by paddr[2]
  localparam logic REG_STAGE      = 1'b0;
  localparam logic REG_PREV_STAGE = 1'b1;

  localparam logic [2:0] STAGE_RESET      = 3'd4;
  localparam logic [2:0] PREV_STAGE_RESET = 3'd0;

  // Stage encodings
  localparam logic [2:0] STAGE_VERTEX    = 3'd0;
  localparam logic [2:0] STAGE_TESS_CTRL = 3'd1;
  localparam logic [2:0] STAGE_FRAGMENT  = 3'd4;

  // Built-in codes with special handling
  localparam logic [15:0] BI_POSITION         = 16'd0;
  localparam logic [15:0] BI_CLIP_DISTANCE    = 16'd3;
  localparam logic [15:0] BI_CULL_DISTANCE    = 16'd4;
  localparam logic [15:0] BI_PRIMITIVE_ID     = 16'd7;
  localparam logic [15:0] BI_TESS_LEVEL_OUTER = 16'd11;
  localparam logic [15:0] BI_TESS_LEVEL_INNER = 16'd12;

  // Sort key: user variables above all built-ins, then code, location, component
  function automatic logic [KEY_W-1:0] sim_key(sim_entry_t e);
    logic [15:0] code;
    code = e.is_builtin ? e.code : 16'h0000;
    return {~e.is_builtin, code, e.location, e.comp_index};
  endfunction

  // True when the pipeline supplies this built-in input by itself
  function automatic logic sim_generated(logic [15:0] code, sim_cfg_t cfg);
    logic gen;
    case (code)
      BI_PRIMITIVE_ID: begin
        gen = (cfg.prev_stage == STAGE_VERTEX) || (cfg.prev_stage == STAGE_TESS_CTRL);
      end
      BI_POSITION: begin
        gen = (cfg.stage == STAGE_FRAGMENT);
      end
      BI_CLIP_DISTANCE, BI_CULL_DISTANCE, BI_TESS_LEVEL_OUTER, BI_TESS_LEVEL_INNER: begin
        gen = 1'b0;
      end
      default: begin
        gen = 1'b1;
      end
    endcase
    return gen;
  endfunction

  // Compatibility of a table entry with an input variable at the same key
  function automatic logic sim_match(sim_entry_t out_e, sim_entry_t in_e);
    logic ok;
    if (in_e.is_builtin) begin
      ok = out_e.is_builtin && (out_e.code == in_e.code) &&
           (out_e.comp_count == in_e.comp_count);
    end else begin
      ok = !out_e.is_builtin && (out_e.patch == in_e.patch) &&
           (out_e.location == in_e.location) &&
           (out_e.comp_index == in_e.comp_index) &&
           (in_e.comp_count <= out_e.comp_count);
    end
    return ok;
  endfunction

endpackage

// File: design/sim_cfg_regs.sv
// APB register file holding the consuming and producing stage codes.
module sim_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output sim_pkg::sim_cfg_t cfg_o
);
  import sim_pkg::*;

  logic [2:0] stage_q, stage_d;
  logic [2:0] prev_stage_q, prev_stage_d;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Decode register writes
  always_comb begin
    stage_d      = stage_q;
    prev_stage_d = prev_stage_q;
    if (wr_en) begin
      case (paddr[2])
        REG_STAGE: begin
          stage_d = pwdata[2:0];
        end
        REG_PREV_STAGE: begin
          prev_stage_d = pwdata[2:0];
        end
        default: begin
          stage_d = stage_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q      <= STAGE_RESET;
      prev_stage_q <= PREV_STAGE_RESET;
    end else begin
      stage_q      <= stage_d;
      prev_stage_q <= prev_stage_d;
    end
  end

  // Return register contents on reads
  always_comb begin
    case (paddr[2])
      REG_STAGE: begin
        prdata = {29'd0, stage_q};
      end
      REG_PREV_STAGE: begin
        prdata = {29'd0, prev_stage_q};
      end
      default: begin
        prdata = 32'd0;
      end
    endcase
  end

  assign cfg_o = '{stage: stage_q, prev_stage: prev_stage_q};

endmodule

// File: design/sim_table_ram.sv
// Variable table storage: one write port, one read port with registered data.
module sim_table_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic                clk_i,
  input  logic                wr_en_i,
  input  logic [AW-1:0]       wr_addr_i,
  input  sim_pkg::sim_entry_t wr_data_i,
  input  logic                rd_en_i,
  input  logic [AW-1:0]       rd_addr_i,
  output sim_pkg::sim_entry_t rd_data_o
);
  import sim_pkg::*;

  sim_entry_t mem [DEPTH];
  sim_entry_t rd_data_q;

  // Write and read the array
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: design/sim_ctrl.sv
// Sequencer: sorted insert, pointer walk for checks, count, mask and result register.
module sim_ctrl #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5,
  parameter int unsigned CNT_W = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sim_pkg::sim_cfg_t   cfg_i,
  // request channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          func_i,
  input  logic                is_builtin_i,
  input  logic [15:0]         builtin_code_i,
  input  logic [4:0]          location_i,
  input  logic [1:0]          component_index_i,
  input  logic [2:0]          component_count_i,
  input  logic                is_patch_constant_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                compatible_o,
  output logic [31:0]         location_mask_o,
  output logic [CNT_W-1:0]    entry_count_o,
  output logic                table_full_o,
  // table memory
  output logic                wr_en_o,
  output logic [AW-1:0]       wr_addr_o,
  output sim_pkg::sim_entry_t wr_data_o,
  output logic                rd_en_o,
  output logic [AW-1:0]       rd_addr_o,
  input  sim_pkg::sim_entry_t rd_data_i
);
  import sim_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CMP,
    S_INS_PUT,
    S_CHK_CMP,
    S_FIN
  } state_e;

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);
  localparam logic [CNT_W-1:0] TWO_C   = CNT_W'(2);

  state_e           state_q, state_d;
  sim_entry_t       item_q, item_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] ptr_q, ptr_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic             verdict_q, verdict_d;
  logic [31:0]      mask_q, mask_d;
  logic             full_q, full_d;
  logic             out_valid_q, out_valid_d;
  logic             out_compat_q, out_compat_d;
  logic [31:0]      out_mask_q, out_mask_d;
  logic [CNT_W-1:0] out_cnt_q, out_cnt_d;
  logic             out_full_q, out_full_d;

  sim_entry_t       in_entry;
  logic [CNT_W-1:0] cnt_m1, idx_m1, idx_m2, ptr_p1;
  logic [KEY_W-1:0] item_key, rd_key;

  // Normalize the incoming word: user variables carry no code
  always_comb begin
    in_entry.is_builtin = is_builtin_i;
    in_entry.code       = is_builtin_i ? builtin_code_i : 16'h0000;
    in_entry.location   = location_i;
    in_entry.comp_index = component_index_i;
    in_entry.comp_count = component_count_i;
    in_entry.patch      = is_patch_constant_i;
  end

  assign cnt_m1   = cnt_q - ONE_C;
  assign idx_m1   = idx_q - ONE_C;
  assign idx_m2   = idx_q - TWO_C;
  assign ptr_p1   = ptr_q + ONE_C;
  assign item_key = sim_key(item_q);
  assign rd_key   = sim_key(rd_data_i);

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and memory accesses
  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    cnt_d        = cnt_q;
    ptr_d        = ptr_q;
    idx_d        = idx_q;
    verdict_d    = verdict_q;
    mask_d       = mask_q;
    full_d       = full_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_compat_d = out_compat_q;
    out_mask_d   = out_mask_q;
    out_cnt_d    = out_cnt_q;
    out_full_d   = out_full_q;
    wr_en_o      = 1'b0;
    wr_addr_o    = idx_q[AW-1:0];
    wr_data_o    = item_q;
    rd_en_o      = 1'b0;
    rd_addr_o    = ptr_q[AW-1:0];

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d = in_entry;
          full_d = 1'b0;
          case (sim_func_e'(func_i))
            FUNC_INSERT: begin
              if (cnt_q == DEPTH_C) begin
                // drop the word and flag it
                full_d  = 1'b1;
                state_d = S_FIN;
              end else begin
                idx_d = cnt_q;
                if (cnt_q == '0) begin
                  state_d = S_INS_PUT;
                end else begin
                  rd_en_o   = 1'b1;
                  rd_addr_o = cnt_m1[AW-1:0];
                  state_d   = S_INS_CMP;
                end
              end
            end
            FUNC_BEGIN: begin
              ptr_d     = '0;
              verdict_d = 1'b1;
              state_d   = S_FIN;
            end
            FUNC_CHECK: begin
              if (!verdict_q || (is_builtin_i && sim_generated(builtin_code_i, cfg_i))) begin
                state_d = S_FIN;
              end else if (ptr_q >= cnt_q) begin
                verdict_d = 1'b0;
                state_d   = S_FIN;
              end else begin
                rd_en_o   = 1'b1;
                rd_addr_o = ptr_q[AW-1:0];
                state_d   = S_CHK_CMP;
              end
            end
            FUNC_CLEAR: begin
              cnt_d   = '0;
              ptr_d   = '0;
              mask_d  = '0;
              state_d = S_FIN;
            end
            default: begin
              state_d = S_FIN;
            end
          endcase
        end
      end

      S_INS_CMP: begin
        // rd_data_i holds the entry just below the free slot idx_q
        if (rd_key >= item_key) begin
          wr_en_o   = 1'b1;
          wr_addr_o = idx_q[AW-1:0];
          wr_data_o = rd_data_i;
          idx_d     = idx_m1;
          if (idx_q == ONE_C) begin
            state_d = S_INS_PUT;
          end else begin
            rd_en_o   = 1'b1;
            rd_addr_o = idx_m2[AW-1:0];
          end
        end else begin
          wr_en_o   = 1'b1;
          wr_addr_o = idx_q[AW-1:0];
          cnt_d     = cnt_q + ONE_C;
          if (!item_q.is_builtin) begin
            mask_d[item_q.location] = 1'b1;
          end
          state_d = S_FIN;
        end
      end

      S_INS_PUT: begin
        wr_en_o   = 1'b1;
        wr_addr_o = idx_q[AW-1:0];
        cnt_d     = cnt_q + ONE_C;
        if (!item_q.is_builtin) begin
          mask_d[item_q.location] = 1'b1;
        end
        state_d = S_FIN;
      end

      S_CHK_CMP: begin
        // rd_data_i holds the entry at the match pointer
        if (rd_key < item_key) begin
          ptr_d = ptr_p1;
          if (ptr_p1 >= cnt_q) begin
            verdict_d = 1'b0;
            state_d   = S_FIN;
          end else begin
            rd_en_o   = 1'b1;
            rd_addr_o = ptr_p1[AW-1:0];
          end
        end else begin
          if (!sim_match(rd_data_i, item_q)) begin
            verdict_d = 1'b0;
          end
          state_d = S_FIN;
        end
      end

      S_FIN: begin
        // load the result register once it is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_compat_d = verdict_q;
          out_mask_d   = mask_q;
          out_cnt_d    = cnt_q;
          out_full_d   = full_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      ptr_q        <= '0;
      idx_q        <= '0;
      verdict_q    <= 1'b1;
      mask_q       <= '0;
      full_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      ptr_q        <= ptr_d;
      idx_q        <= idx_d;
      verdict_q    <= verdict_d;
      mask_q       <= mask_d;
      full_q       <= full_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    item_q       <= item_d;
    out_compat_q <= out_compat_d;
    out_mask_q   <= out_mask_d;
    out_cnt_q    <= out_cnt_d;
    out_full_q   <= out_full_d;
  end

  assign out_valid_o     = out_valid_q;
  assign compatible_o    = out_compat_q;
  assign location_mask_o = out_mask_q;
  assign entry_count_o   = out_cnt_q;
  assign table_full_o    = out_full_q;

endmodule

// File: design/shader_interface_matcher_core.sv
// Top level of the shader interface matcher: config registers, sequencer and table memory.
//
// Request channel (in_valid_i/in_ready_o) takes one word per operation: insert an
// output variable in sorted order, begin a check, check one input variable, or
// clear the table. Every word gives exactly one result word on the result channel
// (out_valid_o/out_ready_i): running verdict, location mask, entry count, full flag.
// Stage codes are to be written over the APB port only while no word is in flight; the
// block itself does not enforce this. One word is in work at a time. Begin, clear, a
// full-table insert and a skipped check go straight to the result; an insert moves
// entries up until its slot is free, and a check steps over entries below its key or
// runs off the end of the table. The table memory has one read and one write port, so
// the insert shift and the pointer walk go one entry per cycle. The sequencer loads the
// result register in its finish state once that register is free.
// A result waiting in the output register does not block the next word; the
// sequencer holds only when a second result is ready before the first is taken.
// Reset empties the table (count zero), zeroes the match pointer, sets the
// verdict to compatible and loads the stage registers; the table memory itself
// is not cleared and needs no clearing pass.
module shader_interface_matcher_core #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [2:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready,
  // request channel
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [1:0]                           func_i,
  input  logic                                 is_builtin_i,
  input  logic [15:0]                          builtin_code_i,
  input  logic [4:0]                           location_i,
  input  logic [1:0]                           component_index_i,
  input  logic [2:0]                           component_count_i,
  input  logic                                 is_patch_constant_i,
  // result channel
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 compatible_o,
  output logic [31:0]                          location_mask_o,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]     entry_count_o,
  output logic                                 table_full_o
);
  import sim_pkg::*;

  localparam int unsigned AW    = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  sim_cfg_t   cfg;
  logic       wr_en;
  logic [AW-1:0] wr_addr;
  sim_entry_t wr_data;
  logic       rd_en;
  logic [AW-1:0] rd_addr;
  sim_entry_t rd_data;

  sim_cfg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sim_ctrl #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW),
    .CNT_W (CNT_W)
  ) u_ctrl (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_i               (cfg),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .func_i              (func_i),
    .is_builtin_i        (is_builtin_i),
    .builtin_code_i      (builtin_code_i),
    .location_i          (location_i),
    .component_index_i   (component_index_i),
    .component_count_i   (component_count_i),
    .is_patch_constant_i (is_patch_constant_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .compatible_o        (compatible_o),
    .location_mask_o     (location_mask_o),
    .entry_count_o       (entry_count_o),
    .table_full_o        (table_full_o),
    .wr_en_o             (wr_en),
    .wr_addr_o           (wr_addr),
    .wr_data_o           (wr_data),
    .rd_en_o             (rd_en),
    .rd_addr_o           (rd_addr),
    .rd_data_i           (rd_data)
  );

  sim_table_ram #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

endmodule

// File: design/sim_checker.sv
// Port-level checks on the shader interface matcher, bound to the top level.
module sim_checker #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic                             compatible_i,
  input logic [31:0]                      location_mask_i,
  input logic [$clog2(TABLE_DEPTH+1)-1:0] entry_count_i,
  input logic                             table_full_i
);

  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  // Hold a stalled result word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(compatible_i) &&
      $stable(location_mask_i) && $stable(entry_count_i) && $stable(table_full_i))
    else $error("result word changed while stalled");

  // A dropped insert only happens on a full table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && table_full_i |-> entry_count_i == CNT_W'(TABLE_DEPTH))
    else $error("full flag without a full table");

  // Never report more entries than the table holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> entry_count_i <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // Locations are only marked by stored user variables
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (location_mask_i != 32'd0) |-> entry_count_i != '0)
    else $error("location mask set on an empty table");

endmodule

bind shader_interface_matcher_core sim_checker #(
  .TABLE_DEPTH (TABLE_DEPTH)
) u_sim_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .compatible_i    (compatible_o),
  .location_mask_i (location_mask_o),
  .entry_count_i   (entry_count_o),
  .table_full_i    (table_full_o)
);

// File: tb/sv/shader_interface_matcher_core_tb.sv
// Self-checking testbench for the shader interface matcher core.
`timescale 1ns / 1ps

module shader_interface_matcher_core_tb;
  import sim_pkg::*;

  localparam int unsigned DEPTH        = 32;
  localparam int unsigned CNT_W        = $clog2(DEPTH + 1);
  localparam int unsigned CLK_PERIOD   = 10;
  localparam int unsigned RESET_CYCLES = 7;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned RAND_WORDS   = 500;
  localparam int unsigned CALM_WORDS   = 200;
  localparam int unsigned CFG_INTERVAL = 250;
  localparam int unsigned IDLE_PCT     = 14;
  localparam int unsigned MAX_REPORTS  = 40;
  localparam longint      TIMEOUT_NS   = 5_000_000;

  // Stage encodings not named in the package
  localparam logic [2:0] STAGE_TESS_EVAL = 3'd2;
  localparam logic [2:0] STAGE_GEOMETRY  = 3'd3;
  localparam logic [2:0] STAGE_UNDEFINED = 3'd7;

  // Stage pairs swept by the configuration test, extremes included
  localparam logic [2:0] SWEEP_STAGE [6] = '{STAGE_VERTEX, STAGE_UNDEFINED, STAGE_FRAGMENT,
                                            STAGE_GEOMETRY, STAGE_TESS_CTRL, STAGE_TESS_EVAL};
  localparam logic [2:0] SWEEP_PREV  [6] = '{STAGE_VERTEX, STAGE_UNDEFINED, STAGE_TESS_CTRL,
                                            STAGE_FRAGMENT, STAGE_UNDEFINED, STAGE_TESS_EVAL};

  // One request word
  typedef struct {
    sim_func_e  func;
    sim_entry_t v;
  } req_t;

  // One result word
  typedef struct packed {
    logic             compatible;
    logic [31:0]      loc_mask;
    logic [CNT_W-1:0] entries;
    logic             full;
  } status_t;

  logic             clk_i               = 1'b0;
  logic             rst_ni              = 1'b0;
  logic             psel                = 1'b0;
  logic             penable             = 1'b0;
  logic             pwrite              = 1'b0;
  logic [2:0]       paddr               = '0;
  logic [31:0]      pwdata              = '0;
  logic [31:0]      prdata;
  logic             pready;
  logic             in_valid_i          = 1'b0;
  logic             in_ready_o;
  logic [1:0]       func_i              = '0;
  logic             is_builtin_i        = 1'b0;
  logic [15:0]      builtin_code_i      = '0;
  logic [4:0]       location_i          = '0;
  logic [1:0]       component_index_i   = '0;
  logic [2:0]       component_count_i   = '0;
  logic             is_patch_constant_i = 1'b0;
  logic             out_valid_o;
  logic             out_ready_i         = 1'b0;
  logic             compatible_o;
  logic [31:0]      location_mask_o;
  logic [CNT_W-1:0] entry_count_o;
  logic             table_full_o;

  // Shadow of the output-variable table and the running check
  sim_entry_t  out_table [DEPTH];
  int unsigned out_count      = 0;
  int unsigned walk_ptr       = 0;
  logic        match_ok       = 1'b1;
  logic [2:0]  cfg_stage      = STAGE_RESET;
  logic [2:0]  cfg_prev_stage = PREV_STAGE_RESET;

  status_t     pending_results [$];
  int unsigned errors     = 0;
  int unsigned words_sent = 0;
  bit          calm       = 1'b0;

  shader_interface_matcher_core #(
    .TABLE_DEPTH(DEPTH)
  ) i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .func_i             (func_i),
    .is_builtin_i       (is_builtin_i),
    .builtin_code_i     (builtin_code_i),
    .location_i         (location_i),
    .component_index_i  (component_index_i),
    .component_count_i  (component_count_i),
    .is_patch_constant_i(is_patch_constant_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .compatible_o       (compatible_o),
    .location_mask_o    (location_mask_o),
    .entry_count_o      (entry_count_o),
    .table_full_o       (table_full_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Order in the table: built-ins by code first, user variables after them
  function automatic logic [23:0] sort_rank(sim_entry_t e);
    logic [15:0] c;
    c = e.is_builtin ? e.code : 16'h0000;
    return {!e.is_builtin, c, e.location, e.comp_index};
  endfunction

  // Built-in inputs that the pipeline fills in without a matching output
  function automatic bit pipeline_supplies(logic [15:0] code);
    bit gen;
    case (code)
      BI_PRIMITIVE_ID: gen = (cfg_prev_stage == STAGE_VERTEX) ||
                             (cfg_prev_stage == STAGE_TESS_CTRL);
      BI_POSITION:     gen = (cfg_stage == STAGE_FRAGMENT);
      BI_CLIP_DISTANCE, BI_CULL_DISTANCE,
      BI_TESS_LEVEL_OUTER, BI_TESS_LEVEL_INNER: gen = 1'b0;
      default:         gen = 1'b1;
    endcase
    return gen;
  endfunction

  // Advance the forward-only pointer and judge one input variable
  function automatic void judge_input(sim_entry_t v);
    sim_entry_t o;
    bit         ok;
    if (!match_ok) return;
    if (v.is_builtin && pipeline_supplies(v.code)) return;
    while (walk_ptr < out_count && sort_rank(out_table[walk_ptr]) < sort_rank(v)) walk_ptr++;
    if (walk_ptr >= out_count) begin
      match_ok = 1'b0;
      return;
    end
    o = out_table[walk_ptr];
    if (v.is_builtin) begin
      ok = o.is_builtin && (o.code == v.code) && (o.comp_count == v.comp_count);
    end else begin
      ok = !o.is_builtin && (o.patch == v.patch) && (o.location == v.location) &&
           (o.comp_index == v.comp_index) && (v.comp_count <= o.comp_count);
    end
    if (!ok) match_ok = 1'b0;
  endfunction

  // Apply one accepted word to the shadow state and return the result it gives
  function automatic status_t interface_match_step(req_t r);
    sim_entry_t  v;
    status_t     s;
    int unsigned pos;
    int unsigned k;
    v = r.v;
    if (!v.is_builtin) v.code = '0;
    s.full = 1'b0;
    case (r.func)
      FUNC_INSERT: begin
        if (out_count >= DEPTH) begin
          s.full = 1'b1;
        end else begin
          pos = 0;
          while (pos < out_count && sort_rank(out_table[pos]) < sort_rank(v)) pos++;
          for (k = out_count; k > pos; k--) out_table[k] = out_table[k - 1];
          out_table[pos] = v;
          out_count++;
        end
      end
      FUNC_BEGIN: begin
        walk_ptr = 0;
        match_ok = 1'b1;
      end
      FUNC_CHECK: begin
        judge_input(v);
      end
      default: begin
        out_count = 0;
        walk_ptr  = 0;
      end
    endcase
    s.compatible = match_ok;
    s.loc_mask   = '0;
    for (k = 0; k < out_count; k++) begin
      if (!out_table[k].is_builtin) s.loc_mask[out_table[k].location] = 1'b1;
    end
    s.entries = CNT_W'(out_count);
    return s;
  endfunction

  function automatic req_t word_of(sim_func_e f, sim_entry_t e);
    req_t r;
    r.func = f;
    r.v    = e;
    return r;
  endfunction

  function automatic sim_entry_t bvar(logic [15:0] code, logic [2:0] cc);
    sim_entry_t e;
    e            = '0;
    e.is_builtin = 1'b1;
    e.code       = code;
    e.comp_count = cc;
    return e;
  endfunction

  function automatic sim_entry_t uvar(logic [4:0] loc, logic [1:0] ci, logic [2:0] cc,
                                      logic patch);
    sim_entry_t e;
    e            = '0;
    e.location   = loc;
    e.comp_index = ci;
    e.comp_count = cc;
    e.patch      = patch;
    return e;
  endfunction

  // Random variable, biased toward the built-ins with special handling
  function automatic sim_entry_t random_var();
    sim_entry_t  e;
    logic [31:0] r;
    r            = $urandom;
    e            = r[$bits(sim_entry_t)-1:0];
    e.is_builtin = ($urandom_range(2) == 0);
    case ($urandom_range(9))
      0:       e.code = BI_POSITION;
      1:       e.code = BI_CLIP_DISTANCE;
      2:       e.code = BI_CULL_DISTANCE;
      3:       e.code = BI_PRIMITIVE_ID;
      4:       e.code = BI_TESS_LEVEL_OUTER;
      5:       e.code = BI_TESS_LEVEL_INNER;
      6, 7:    e.code = 16'($urandom_range(40, 13));
      default: ;
    endcase
    if ($urandom_range(7) != 0) e.comp_count = 3'($urandom_range(4, 1));
    return e;
  endfunction

  // Send one word, idling first at random, and record its result
  task automatic send_word(input req_t r);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < IDLE_PCT);
    end
    in_valid_i          <= 1'b1;
    func_i              <= r.func;
    is_builtin_i        <= r.v.is_builtin;
    builtin_code_i      <= r.v.code;
    location_i          <= r.v.location;
    component_index_i   <= r.v.comp_index;
    component_count_i   <= r.v.comp_count;
    is_patch_constant_i <= r.v.patch;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(interface_match_step(r));
    words_sent++;
  endtask

  // Drain the block, then write one register through the APB port
  task automatic write_reg(input logic reg_sel, input logic [2:0] value);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= {29'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_sel == REG_STAGE) begin
      cfg_stage = value;
    end else begin
      cfg_prev_stage = value;
    end
  endtask

  task automatic set_stages(input logic [2:0] stage_val, input logic [2:0] prev_val);
    write_reg(REG_STAGE, stage_val);
    write_reg(REG_PREV_STAGE, prev_val);
  endtask

  // Fill the table, begin a check and walk its sorted outputs back as inputs
  task automatic run_session(input int unsigned min_outs, input int unsigned max_outs);
    sim_entry_t  snap [$];
    sim_entry_t  e;
    int unsigned pick;
    int unsigned k;
    logic [31:0] r;
    if ($urandom_range(3) != 0) send_word(word_of(FUNC_CLEAR, random_var()));
    repeat ($urandom_range(max_outs, min_outs)) send_word(word_of(FUNC_INSERT, random_var()));
    send_word(word_of(FUNC_BEGIN, random_var()));
    for (k = 0; k < out_count; k++) snap.push_back(out_table[k]);
    foreach (snap[i]) begin
      pick = $urandom_range(99);
      // leave some outputs unread
      if (pick < 8) continue;
      // slip in a built-in the pipeline may supply itself
      if (pick < 16) begin
        e = bvar(($urandom_range(1) == 0) ? BI_POSITION : BI_PRIMITIVE_ID, 3'($urandom));
        if ($urandom_range(2) == 0) e.code = 16'($urandom_range(65535, 13));
        send_word(word_of(FUNC_CHECK, e));
      end
      e = snap[i];
      if (!e.is_builtin) begin
        e.comp_count = 3'($urandom_range(e.comp_count, 0));
        e.code       = 16'($urandom);
      end
      // break the match on one field
      if (pick >= 90) begin
        case ($urandom_range(4))
          0:       e.patch      = !e.patch;
          1:       e.location   = e.location + 5'd1;
          2:       e.comp_index = e.comp_index + 2'd1;
          3:       e.comp_count = e.comp_count + 3'd1;
          default: e.is_builtin = !e.is_builtin;
        endcase
      end
      // unrelated word of any kind
      if (pick >= 96) begin
        r = $urandom;
        send_word(word_of(sim_func_e'($urandom_range(3)), r[$bits(sim_entry_t)-1:0]));
      end
      send_word(word_of(FUNC_CHECK, e));
    end
    // input with no output left to match
    if ($urandom_range(4) == 0) send_word(word_of(FUNC_CHECK, random_var()));
  endtask

  task automatic test_directed_walk();
    send_word(word_of(FUNC_CLEAR,  uvar(5'd0, 2'd0, 3'd0, 1'b0)));
    send_word(word_of(FUNC_INSERT, bvar(BI_POSITION, 3'd4)));
    send_word(word_of(FUNC_INSERT, uvar(5'd31, 2'd3, 3'd7, 1'b1)));
    send_word(word_of(FUNC_INSERT, uvar(5'd0, 2'd0, 3'd2, 1'b0)));
    send_word(word_of(FUNC_INSERT, bvar(16'hFFFF, 3'd1)));
    send_word(word_of(FUNC_INSERT, bvar(BI_CLIP_DISTANCE, 3'd2)));
    send_word(word_of(FUNC_INSERT, bvar(BI_PRIMITIVE_ID, 3'd1)));
    send_word(word_of(FUNC_BEGIN,  uvar(5'd0, 2'd0, 3'd0, 1'b0)));
    // position into fragment and primitive id after vertex are supplied
    send_word(word_of(FUNC_CHECK,  bvar(BI_POSITION, 3'd4)));
    send_word(word_of(FUNC_CHECK,  bvar(BI_CLIP_DISTANCE, 3'd2)));
    send_word(word_of(FUNC_CHECK,  bvar(BI_PRIMITIVE_ID, 3'd3)));
    send_word(word_of(FUNC_CHECK,  bvar(16'hFFFF, 3'd7)));
    send_word(word_of(FUNC_CHECK,  uvar(5'd0, 2'd0, 3'd1, 1'b0)));
    send_word(word_of(FUNC_CHECK,  uvar(5'd31, 2'd3, 3'd7, 1'b1)));
    send_word(word_of(FUNC_CHECK,  uvar(5'd31, 2'd3, 3'd0, 1'b1)));
    // patch flag differs: verdict drops and stays down
    send_word(word_of(FUNC_CHECK,  uvar(5'd31, 2'd3, 3'd1, 1'b0)));
    send_word(word_of(FUNC_CHECK,  uvar(5'd0, 2'd0, 3'd1, 1'b0)));
    // clear keeps the verdict
    send_word(word_of(FUNC_CLEAR,  bvar(16'hFFFF, 3'd7)));
    send_word(word_of(FUNC_BEGIN,  bvar(16'hFFFF, 3'd7)));
    send_word(word_of(FUNC_CHECK,  bvar(BI_CULL_DISTANCE, 3'd1)));
    // insert while a check is open, then run past the end
    send_word(word_of(FUNC_BEGIN,  uvar(5'd0, 2'd0, 3'd0, 1'b0)));
    send_word(word_of(FUNC_INSERT, uvar(5'd5, 2'd1, 3'd3, 1'b0)));
    send_word(word_of(FUNC_CHECK,  uvar(5'd9, 2'd0, 3'd1, 1'b0)));
    send_word(word_of(FUNC_BEGIN,  uvar(5'd0, 2'd0, 3'd0, 1'b0)));
    send_word(word_of(FUNC_CHECK,  bvar(BI_TESS_LEVEL_OUTER, 3'd4)));
    send_word(word_of(FUNC_CHECK,  bvar(BI_TESS_LEVEL_INNER, 3'd2)));
  endtask

  // More inserts than the table holds
  task automatic test_full_table();
    run_session(DEPTH + 2, DEPTH + 2);
  endtask

  task automatic test_stage_settings();
    foreach (SWEEP_STAGE[i]) begin
      set_stages(SWEEP_STAGE[i], SWEEP_PREV[i]);
      repeat (6) run_session(0, 10);
    end
  endtask

  // Long random traffic, opening with a stretch free of idling
  task automatic test_random_traffic();
    int unsigned start;
    int unsigned next_cfg;
    start    = words_sent;
    next_cfg = start + CFG_INTERVAL;
    calm     = 1'b1;
    while (words_sent < start + RAND_WORDS) begin
      if (words_sent >= start + CALM_WORDS) calm = 1'b0;
      if (words_sent >= next_cfg) begin
        set_stages(3'($urandom), 3'($urandom));
        next_cfg += CFG_INTERVAL;
      end
      run_session(0, ($urandom_range(9) == 0) ? DEPTH : 8);
    end
    calm = 1'b0;
  endtask

  // Stall the result channel at random
  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      if (errors < MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
      errors++;
    end
  endtask

  // Compare each result word with the oldest expectation
  always @(posedge clk_i) begin : check_results
    status_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        if (errors < MAX_REPORTS) begin
          $display("%0t: unexpected result word, expected none, actual %0h", $time,
                   {compatible_o, location_mask_o, entry_count_o, table_full_o});
        end
        errors++;
      end else begin
        want = pending_results.pop_front();
        compare_field("compatible", 32'(want.compatible), 32'(compatible_o));
        compare_field("location_mask", want.loc_mask, location_mask_o);
        compare_field("entry_count", 32'(want.entries), 32'(entry_count_o));
        compare_field("table_full", 32'(want.full), 32'(table_full_o));
      end
    end
  end

  initial begin : run_tests
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_walk();
    test_full_table();
    test_stage_settings();
    test_random_traffic();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("shader_interface_matcher_core verification clean");
    end else begin
      $display("shader_interface_matcher_core verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("shader_interface_matcher_core verification failed");
    $finish;
  end

endmodule
